/* src/assert_macros.svh */
// Assertion helpers; the using module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds whenever out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ubxfp_pkg.sv */
package ubxfp_pkg;

  // Input item selector (s_tuser)
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_RESYNC = 2'd2;

  // Result kind (m_tuser)
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [7:0] SYNC1_BYTE = 8'hB5;
  localparam logic [7:0] SYNC2_BYTE = 8'h62;

  typedef struct packed {
    logic       done;
    logic [7:0] msg_class;
    logic [7:0] msg_id;
    logic [9:0] payload_length;
  } frame_info_t;

endpackage

/* src/ubxfp_ram.sv */
module ubxfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/ubxfp_parser.sv */
`include "assert_macros.svh"

module ubxfp_parser import ubxfp_pkg::*; #(
  parameter int PAYLOAD_BYTES = 512,
  localparam int ADDR_W = $clog2(PAYLOAD_BYTES),
  localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              resync,
  input  logic [7:0]        rx_byte,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output frame_info_t       frame
);

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
    PH_BODY, PH_CHK_A, PH_CHK_B
  } phase_t;

  phase_t             phase, phase_next;
  logic [7:0]         sum_a, sum_a_next;
  logic [7:0]         sum_b, sum_b_next;
  logic [7:0]         frame_class, frame_class_next;
  logic [7:0]         frame_id, frame_id_next;
  logic [15:0]        frame_length, frame_length_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic [7:0]         acc_a, acc_b;
  logic [15:0]        len_full;
  logic [FILL_W-1:0]  fill_inc;

  assign acc_a    = sum_a + rx_byte;
  assign acc_b    = sum_b + acc_a;
  assign len_full = {rx_byte, frame_length[7:0]};
  assign fill_inc = fill + 1'b1;
  assign wr_addr  = fill[ADDR_W-1:0];
  assign wr_data  = rx_byte;

  always_comb begin
    phase_next        = phase;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    frame_class_next  = frame_class;
    frame_id_next     = frame_id;
    frame_length_next = frame_length;
    fill_next         = fill;
    wr_en             = 1'b0;
    frame             = '0;
    if (resync) begin
      phase_next        = PH_SYNC1;
      frame_length_next = '0;
      fill_next         = '0;
    end else if (push) begin
      case (phase)
        PH_SYNC1: begin
          if (rx_byte == SYNC1_BYTE) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (rx_byte == SYNC2_BYTE) begin
            phase_next = PH_CLASS;
            sum_a_next = '0;
            sum_b_next = '0;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          frame_class_next = rx_byte;
          sum_a_next       = acc_a;
          sum_b_next       = acc_b;
          phase_next       = PH_ID;
        end
        PH_ID: begin
          frame_id_next = rx_byte;
          sum_a_next    = acc_a;
          sum_b_next    = acc_b;
          phase_next    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_length_next = {8'h00, rx_byte};
          sum_a_next        = acc_a;
          sum_b_next        = acc_b;
          phase_next        = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_length_next = len_full;
          sum_a_next        = acc_a;
          sum_b_next        = acc_b;
          if (len_full == '0) begin
            phase_next = PH_CHK_A;
          end else if (int'(len_full) <= PAYLOAD_BYTES) begin
            fill_next  = '0;
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_SYNC1;  // too long for the store
          end
        end
        PH_BODY: begin
          wr_en      = 1'b1;
          fill_next  = fill_inc;
          sum_a_next = acc_a;
          sum_b_next = acc_b;
          if (int'(fill_inc) >= int'(frame_length)) phase_next = PH_CHK_A;
        end
        PH_CHK_A: begin
          phase_next = (rx_byte == sum_a) ? PH_CHK_B : PH_SYNC1;
        end
        PH_CHK_B: begin
          phase_next = PH_SYNC1;
          if (rx_byte == sum_b) begin
            frame.done           = 1'b1;
            frame.msg_class      = frame_class;
            frame.msg_id         = frame_id;
            frame.payload_length = frame_length[9:0];
          end
        end
        default: phase_next = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      sum_a        <= '0;
      sum_b        <= '0;
      frame_class  <= '0;
      frame_id     <= '0;
      frame_length <= '0;
      fill         <= '0;
    end else begin
      phase        <= phase_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      frame_class  <= frame_class_next;
      frame_id     <= frame_id_next;
      frame_length <= frame_length_next;
      fill         <= fill_next;
    end
  end

  `ASSERT_IMPLIES(a_body_fill, phase == PH_BODY, int'(fill) < int'(frame_length), "fill past length")
  `ASSERT_IMPLIES(a_body_len, phase == PH_BODY, frame_length != '0 && int'(frame_length) <= PAYLOAD_BYTES, "bad body length")
  `ASSERT_IMPLIES(a_done_phase, frame.done, phase == PH_CHK_B && push, "frame done outside checksum")

endmodule

/* src/ubx_frame_parser_core.sv */
// Path from input item accept to m_tvalid: stage 1, then the output register (store read is registered).
// Throughput: one item per cycle while s_tready is high; output register plus a stage
//   in front of it keep s_tready high while one result waits on m_tready, low when both hold results.
// Reset (rst, synchronous): parser back to hunting the first sync byte,
//   sums and frame header zeroed, pipeline emptied; payload store not cleared.
`include "assert_macros.svh"

module ubx_frame_parser_core import ubxfp_pkg::*; #(
  parameter int PAYLOAD_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] data_byte, [16:8] read_index, [23:17] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] msg_class, [15:8] msg_id,
                                 // [25:16] payload_length, [33:26] read_byte, [39:34] zero
  output logic        m_tuser    // [0] kind
);

  localparam int ADDR_W = $clog2(PAYLOAD_BYTES);

  logic              accept, push, resync, rd_req, s1_adv, rd_oob;
  logic [7:0]        data_byte;
  logic [8:0]        read_index;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        ram_rdata;
  frame_info_t       frame;

  // stage 1: result captured, store read in flight
  logic        s1_valid, s1_kind, s1_oob;
  logic [7:0]  s1_class, s1_id;
  logic [9:0]  s1_len;

  // output register
  logic        out_valid, out_kind;
  logic [7:0]  out_class, out_id, out_rbyte;
  logic [9:0]  out_len;

  assign data_byte  = s_tdata[7:0];
  assign read_index = s_tdata[16:8];

  // stage 1 moves when the output register is empty or being drained
  assign s1_adv   = !out_valid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (s_tuser == OP_PUSH);
  assign resync   = accept && (s_tuser == OP_RESYNC);
  assign rd_req   = accept && (s_tuser == OP_READ);
  assign rd_oob   = int'(read_index) >= PAYLOAD_BYTES;

  ubxfp_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .resync  (resync),
    .rx_byte (data_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .frame   (frame)
  );

  // Read enable only on read items, so rd_data holds while stage 1 stalls.
  ubxfp_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_req),
    .rd_addr (ADDR_W'(read_index)),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          out_kind  <= s1_kind;
          out_class <= s1_class;
          out_id    <= s1_id;
          out_len   <= s1_len;
          out_rbyte <= (s1_kind == KIND_READ && !s1_oob) ? ram_rdata : 8'h00;
        end
      end
      if (s_tready) begin
        s1_valid <= rd_req || frame.done;
        if (rd_req) begin
          s1_kind  <= KIND_READ;
          s1_oob   <= rd_oob;
          s1_class <= '0;
          s1_id    <= '0;
          s1_len   <= '0;
        end else if (frame.done) begin
          s1_kind  <= KIND_FRAME;
          s1_oob   <= 1'b0;
          s1_class <= frame.msg_class;
          s1_id    <= frame.msg_id;
          s1_len   <= frame.payload_length;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'b0, out_rbyte, out_len, out_id, out_class};

  `ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid && $stable(ram_rdata) && $stable(s1_kind), "stalled read data changed")
  `ASSERT_NEXT(a_read_lands, rd_req, s1_valid && s1_kind == KIND_READ, "read item lost")
  `ASSERT_IMPLIES(a_frame_no_byte, m_tvalid && m_tuser == KIND_FRAME, m_tdata[33:26] == 8'h00, "frame result with read byte")
  `ASSERT_IMPLIES(a_read_no_hdr, m_tvalid && m_tuser == KIND_READ, m_tdata[25:0] == 26'd0, "read result with header")

endmodule
